@@ rtl/tile_coverage_mask_window_and_assert.svh @@
// Assertion macros for the tile coverage mask block.
// Used by tile_coverage_mask_window_and.sv; no other dependencies.
`ifndef TILE_COVERAGE_MASK_WINDOW_AND_ASSERT_SVH
`define TILE_COVERAGE_MASK_WINDOW_AND_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Property holds at every clock edge outside reset.
`define TCM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("tile coverage assertion failed");
// Condition never holds outside reset.
`define TCM_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("tile coverage forbidden condition seen");
`else
`define TCM_ASSERT(lbl, clk, rst_n, prop)
`define TCM_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

@@ rtl/tcm_pkg.sv @@
// Shared types and constants for the tile coverage mask block.
// No dependencies; used by the interfaces and the top level.
`default_nettype none

package tcm_pkg;

  localparam int ATLAS_SIZE = 512;
  localparam int SRC_MAX    = 2048;

  localparam int COORD_W = 11;               // pixel coordinate field
  localparam int TEXEL_W = 9;                // texel coordinate field
  localparam int SIZE_W  = 12;               // width/height register
  localparam int CHAN_W  = 16;
  localparam int COUNT_W = 23;
  localparam int CFG_IDX_W = 1;

  localparam int ADDR_W    = 2 * COORD_W;
  localparam int MAP_DEPTH = SRC_MAX * SRC_MAX;
  localparam int MUL_T_W   = TEXEL_W + 1;
  localparam int PROD_W    = MUL_T_W + SIZE_W;
  localparam int BND_W     = SIZE_W + 1;

  localparam logic [SIZE_W-1:0]  SIZE_RESET = SIZE_W'(1536);
  localparam logic [SIZE_W-1:0]  SIZE_CAP   = SIZE_W'(SRC_MAX);
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 1'b0,
    REG_SRC_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_BOUND = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [COORD_W-1:0] pix_x;
    logic [COORD_W-1:0] pix_y;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic               water_flag;
    logic               land_flag;
    logic [TEXEL_W-1:0] texel_x;
    logic [TEXEL_W-1:0] texel_y;
  } tcm_in_t;

  typedef struct packed {
    logic               pixel_shown;
    logic [COUNT_W-1:0] shown_count;
    logic               covered;
  } tcm_out_t;

endpackage

`default_nettype wire

@@ rtl/tcm_if.sv @@
// Request channel interfaces: input items, results and register writes.
// Depends on tcm_pkg.
`default_nettype none

interface tcm_in_if;
  import tcm_pkg::*;
  logic    valid;
  logic    ready;
  tcm_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tcm_out_if;
  import tcm_pkg::*;
  logic     valid;
  logic     ready;
  tcm_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tcm_cfg_if;
  import tcm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] idx;
  logic [SIZE_W-1:0]    wdata;
  modport source (output valid, output idx, output wdata, input ready);
  modport sink   (input valid, input idx, input wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/tile_coverage_mask_window_and.sv @@
// Tile coverage mask: a write, clear or spare opcode goes from accept through the emit state to
// the output register; a query forms the window bounds, then walks the window reading up to the
// window area in bits (36 for a 6x6 window), fewer when a clear bit ends the walk early. A new
// request is taken only once the last result is in the output register; the single read port
// of the good map, one bit a cycle, sets the query rate. Reset (rst_ni low, async) clears the
// count, sequencer and output valid and sets both size registers to 1536; the map is not cleared.
`default_nettype none
`include "tile_coverage_mask_window_and_assert.svh"

module tile_coverage_mask_window_and (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tcm_cfg_if.sink    cfg_i,
  tcm_in_if.sink     in_i,
  tcm_out_if.source  out_o
);
  import tcm_pkg::*;

  // ---------------------------------------------------------------------
  // Size registers. Values above SRC_MAX act as SRC_MAX.
  // ---------------------------------------------------------------------
  logic [SIZE_W-1:0] width_q, height_q;
  logic [SIZE_W-1:0] eff_w, eff_h;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_RESET;
      height_q <= SIZE_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.idx))
        REG_SRC_WIDTH:  width_q  <= cfg_i.wdata;
        REG_SRC_HEIGHT: height_q <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  assign eff_w = (width_q  > SIZE_CAP) ? SIZE_CAP : width_q;
  assign eff_h = (height_q > SIZE_CAP) ? SIZE_CAP : height_q;

  // ---------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------
  state_e             state_q, state_d;
  logic [2:0]         step_q;          // bound step, 0..4
  logic [TEXEL_W-1:0] tx_q, ty_q;
  logic [PROD_W-1:0]  prod_q;
  logic [COORD_W-1:0] x0_q, y0_q, x_q, y_q;
  logic [SIZE_W-1:0]  x1_q, y1_q;
  logic               rd_pend_q, rd_last_q, issue_done_q;
  logic               rd_bit_q;
  logic               res_shown_q, res_cov_q;
  logic [COUNT_W-1:0] count_q;
  logic               out_valid_q;
  tcm_out_t           out_data_q;

  logic in_req, out_free;
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_req     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // Write path: good = water or (valid and land); shown = valid and land.
  logic pix_valid, pix_shown, pix_good;
  assign pix_valid = (in_i.data.red != '0) || (in_i.data.green != '0) ||
                     (in_i.data.blue != '0);
  assign pix_shown = pix_valid && in_i.data.land_flag;
  assign pix_good  = in_i.data.water_flag || pix_shown;

  // ---------------------------------------------------------------------
  // Shared multiplier: step 0..3 forms tx*w, (tx+1)*w, ty*h, (ty+1)*h.
  // The product is registered; the bound is taken from it one step later.
  // ---------------------------------------------------------------------
  logic [MUL_T_W-1:0] mul_t;
  logic [SIZE_W-1:0]  mul_n;
  logic [PROD_W-1:0]  mul_res;
  logic [PROD_W-1:0]  scaled;
  logic [BND_W-1:0]   bnd_a, bnd_b;
  logic [SIZE_W-1:0]  bnd_n;
  logic [COORD_W-1:0] bnd_lo;
  logic [SIZE_W-1:0]  bnd_hi;

  always_comb begin
    mul_t = {1'b0, step_q[1] ? ty_q : tx_q} + MUL_T_W'(step_q[0]);
    mul_n = step_q[1] ? eff_h : eff_w;
  end
  assign mul_res = PROD_W'(mul_t) * PROD_W'(mul_n);

  // Bound from the previous step: steps 1,2 are x, steps 3,4 are y.
  assign bnd_n  = (step_q >= 3'd3) ? eff_h : eff_w;
  assign scaled = PROD_W'(prod_q / ATLAS_SIZE);
  assign bnd_a  = scaled[BND_W-1:0];
  assign bnd_b  = bnd_a + BND_W'(2);
  assign bnd_lo = (bnd_a != '0) ? COORD_W'(bnd_a - BND_W'(1)) : '0;
  assign bnd_hi = (bnd_b < {1'b0, bnd_n}) ? bnd_b[SIZE_W-1:0] : bnd_n;

  // ---------------------------------------------------------------------
  // Window walk, one map bit read per cycle, row-major.
  // ---------------------------------------------------------------------
  logic win_empty, x_end, y_end, walk_issue;
  logic [ADDR_W-1:0] rd_addr;
  assign win_empty  = ({1'b0, x0_q} >= x1_q) || ({1'b0, y0_q} >= y1_q);
  assign x_end      = (({1'b0, x_q} + SIZE_W'(1)) == x1_q);
  assign y_end      = (({1'b0, y_q} + SIZE_W'(1)) == y1_q);
  assign rd_addr    = {y_q, x_q};

  // Early exit on the first clear bit; covered when the last bit comes back set or the window is empty.
  logic walk_done, walk_cov;
  always_comb begin
    walk_done = 1'b0;
    walk_cov  = 1'b1;
    if (win_empty) begin
      walk_done = 1'b1;
    end else if (rd_pend_q && !rd_bit_q) begin
      walk_done = 1'b1;
      walk_cov  = 1'b0;
    end else if (rd_pend_q && rd_last_q) begin
      walk_done = 1'b1;
    end
  end
  assign walk_issue = (state_q == ST_WALK) && !walk_done && !issue_done_q;

  // ---------------------------------------------------------------------
  // Good map: one write port (pixel writes), one read port (window walk).
  // ---------------------------------------------------------------------
  logic good_map_q [MAP_DEPTH];
  logic wr_en;
  assign wr_en = in_req && (op_e'(in_i.data.opcode) == OP_WRITE);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      good_map_q[{in_i.data.pix_y, in_i.data.pix_x}] <= pix_good;
    end
    if (walk_issue) begin
      rd_bit_q <= good_map_q[rd_addr];
    end
  end

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_req) begin
        state_d = (op_e'(in_i.data.opcode) == OP_QUERY) ? ST_BOUND : ST_EMIT;
      end
      ST_BOUND: if (step_q == 3'd4) begin
        state_d = ST_WALK;
      end
      ST_WALK:  if (walk_done) begin
        state_d = ST_EMIT;
      end
      ST_EMIT:  if (out_free) begin
        state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= '0;
      rd_pend_q    <= 1'b0;
      rd_last_q    <= 1'b0;
      issue_done_q <= 1'b0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (in_req) begin
        step_q <= '0;
        unique case (op_e'(in_i.data.opcode))
          OP_WRITE: if (pix_shown && count_q != COUNT_MAX) begin
            count_q <= count_q + COUNT_W'(1);
          end
          OP_CLEAR: count_q <= '0;
          OP_QUERY: ;
          default:  ;
        endcase
      end else if (state_q == ST_BOUND) begin
        step_q <= step_q + 3'd1;
      end

      if (state_q == ST_WALK && !walk_done) begin
        rd_pend_q <= walk_issue;
        rd_last_q <= x_end && y_end;
        if (walk_issue && x_end && y_end) begin
          issue_done_q <= 1'b1;
        end
      end else begin
        rd_pend_q    <= 1'b0;
        rd_last_q    <= 1'b0;
        issue_done_q <= 1'b0;
      end

      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_req) begin
      tx_q        <= in_i.data.texel_x;
      ty_q        <= in_i.data.texel_y;
      res_shown_q <= (op_e'(in_i.data.opcode) == OP_WRITE) && pix_shown;
      res_cov_q   <= 1'b0;
    end

    if (state_q == ST_BOUND) begin
      prod_q <= mul_res;
      case (step_q)
        3'd1: begin
          x0_q <= bnd_lo;
          x_q  <= bnd_lo;
        end
        3'd2: x1_q <= bnd_hi;
        3'd3: begin
          y0_q <= bnd_lo;
          y_q  <= bnd_lo;
        end
        3'd4: y1_q <= bnd_hi;
        default: ;
      endcase
    end

    if (walk_issue) begin
      if (x_end) begin
        x_q <= x0_q;
        y_q <= y_q + COORD_W'(1);
      end else begin
        x_q <= x_q + COORD_W'(1);
      end
    end

    if (state_q == ST_WALK && walk_done) begin
      res_cov_q <= walk_cov;
    end

    if (state_q == ST_EMIT && out_free) begin
      out_data_q.pixel_shown <= res_shown_q;
      out_data_q.shown_count <= count_q;
      out_data_q.covered     <= res_cov_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `TCM_ASSERT(a_walk_in_window, clk_i, rst_ni,
    walk_issue |-> ({1'b0, x_q} < x1_q) && ({1'b0, y_q} < y1_q))
  `TCM_ASSERT(a_read_follows_issue, clk_i, rst_ni,
    rd_pend_q |-> $past(walk_issue))
  `TCM_ASSERT(a_emit_loads_output, clk_i, rst_ni,
    (state_q == ST_EMIT) && out_free |=> out_valid_q && (state_q == ST_IDLE))
  `TCM_ASSERT(a_count_step, clk_i, rst_ni,
    wr_en && pix_shown && (count_q != COUNT_MAX) |=>
      count_q == $past(count_q) + COUNT_W'(1))
  `TCM_ASSERT_NEVER(a_no_accept_busy, clk_i, rst_ni,
    in_req && (rd_pend_q || issue_done_q))

endmodule

`default_nettype wire

@@ tb/sv/tile_coverage_mask_window_and_tb.sv @@
// Self-checking testbench for the tile coverage mask block: pixel writes,
// coverage queries, count clears and size register writes against a local predictor.
// Depends on tcm_pkg, the tcm_*_if interfaces and tile_coverage_mask_window_and.
`default_nettype none

module tile_coverage_mask_window_and_tb;
  import tcm_pkg::*;

  // Opcode 3 has no function; the block must answer it without side effects.
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic clk;
  logic rst_n;

  tcm_in_if  in_ch ();
  tcm_out_if out_ch ();
  tcm_cfg_if cfg_ch ();

  tile_coverage_mask_window_and dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the size registers, the shown-pixel count and
  // the good map. The map is sparse; an entry exists only once it was written,
  // which also tells the stimulus which window bits still need a write.
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0]  width_reg;
  logic [SIZE_W-1:0]  height_reg;
  logic [COUNT_W-1:0] shown_total;
  bit                 good_bits [int];

  tcm_out_t tile_results_due [$];   // one expected result per accepted request
  tcm_out_t oldest_due;
  int       mismatch_count;
  int       requests_sent;
  int       burst_left;
  int       last_tx;
  int       last_ty;

  // Register values above SRC_MAX behave as SRC_MAX.
  function automatic int clip_size(logic [SIZE_W-1:0] v);
    return (v > SRC_MAX) ? SRC_MAX : int'(v);
  endfunction

  // Window [lo, hi) of texel t along an axis of n pixels: one pixel of margin
  // below the scaled start, two above the scaled end, clipped to the image.
  function automatic void texel_span(int t, int n, output int lo, output int hi);
    int a;
    int b;
    a  = t * n / ATLAS_SIZE;
    b  = (t + 1) * n / ATLAS_SIZE + 2;
    lo = (a > 0) ? a - 1 : 0;
    hi = (b < n) ? b : n;
  endfunction

  // Expected result of one accepted request; updates the predictor state.
  function automatic tcm_out_t expected_tile_result(tcm_in_t req);
    tcm_out_t res;
    bit       shown;
    bit       all_good;
    int       x0, x1, y0, y1;
    res = '0;
    case (req.opcode)
      OP_WRITE: begin
        shown = ((req.red | req.green | req.blue) != '0) && req.land_flag;
        // pix fields are 11 bits, so every write lands inside the store
        good_bits[int'(req.pix_y) * SRC_MAX + int'(req.pix_x)] = req.water_flag || shown;
        if (shown && shown_total != COUNT_MAX) shown_total++;
        res.pixel_shown = shown;
      end
      OP_QUERY: begin
        texel_span(int'(req.texel_x), clip_size(width_reg), x0, x1);
        texel_span(int'(req.texel_y), clip_size(height_reg), y0, y1);
        all_good = 1'b1;
        // row-major walk, stops at the first clear bit; empty window stays covered
        for (int y = y0; y < y1; y++)
          for (int x = x0; x < x1; x++)
            if (all_good && !good_bits[y * SRC_MAX + x]) all_good = 1'b0;
        res.covered = all_good;
      end
      OP_CLEAR: shown_total = '0;
      default: ;
    endcase
    res.shown_count = shown_total;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and the time limit.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Time limit for the whole run; hitting it reports mismatches and ends the simulation.
  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and checker.
  // ---------------------------------------------------------------------------

  // Stall behavior changes from mode to mode at random: none, light, heavy.
  initial begin : receiver_stalls
    int stall_left;
    int stall_odds;
    int stall_max;
    int cycles_in_mode;
    stall_left     = 0;
    stall_odds     = 0;
    stall_max      = 1;
    cycles_in_mode = 0;
    out_ch.ready   = 1'b0;
    forever begin
      @(negedge clk);
      if (cycles_in_mode == 0) begin
        case ($urandom_range(0, 2))
          0: begin stall_odds = 0;  stall_max = 1;  end
          1: begin stall_odds = 10; stall_max = 3;  end
          default: begin stall_odds = 40; stall_max = 12; end
        endcase
        cycles_in_mode = $urandom_range(50, 400);
      end
      cycles_in_mode--;
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_odds) begin
        stall_left = $urandom_range(1, stall_max) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    // cap the log; every mismatch still counts
    if (mismatch_count < 100)
      $display("ERROR %0t: %s got %0d want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Each accepted result against the oldest expectation, field by field.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (tile_results_due.size() == 0) begin
        report_mismatch("result with nothing due, count", int'(out_ch.data.shown_count), -1);
      end else begin
        oldest_due = tile_results_due.pop_front();
        if (out_ch.data.pixel_shown !== oldest_due.pixel_shown)
          report_mismatch("pixel_shown", int'(out_ch.data.pixel_shown),
                          int'(oldest_due.pixel_shown));
        if (out_ch.data.shown_count !== oldest_due.shown_count)
          report_mismatch("shown_count", int'(out_ch.data.shown_count),
                          int'(oldest_due.shown_count));
        if (out_ch.data.covered !== oldest_due.covered)
          report_mismatch("covered", int'(out_ch.data.covered), int'(oldest_due.covered));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side.
  // ---------------------------------------------------------------------------

  // Sends one request. Bursts of random length, separated by random gaps;
  // about a quarter of the bursts follow the previous one without a gap.
  task automatic send_request(tcm_in_t req);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= req;
    do @(posedge clk); while (!in_ch.ready);
    tile_results_due.push_back(expected_tile_result(req));
    requests_sent++;
  endtask

  // Drop valid before any pause so a stale request is not taken twice.
  task automatic idle_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Every field random, so unused fields toggle too; colors often zero.
  function automatic tcm_in_t random_request(logic [1:0] op);
    tcm_in_t req;
    req.opcode     = op;
    req.pix_x      = COORD_W'($urandom_range(0, 2047));
    req.pix_y      = COORD_W'($urandom_range(0, 2047));
    req.red        = ($urandom_range(0, 9) < 3) ? '0 : CHAN_W'($urandom);
    req.green      = ($urandom_range(0, 9) < 3) ? '0 : CHAN_W'($urandom);
    req.blue       = ($urandom_range(0, 9) < 3) ? '0 : CHAN_W'($urandom);
    req.water_flag = 1'($urandom_range(0, 1));
    req.land_flag  = 1'($urandom_range(0, 1));
    req.texel_x    = TEXEL_W'($urandom_range(0, 511));
    req.texel_y    = TEXEL_W'($urandom_range(0, 511));
    return req;
  endfunction

  task automatic send_write_fields(int x, int y, int r, int g, int b, bit water, bit land);
    tcm_in_t req;
    req            = random_request(OP_WRITE);
    req.pix_x      = COORD_W'(x);
    req.pix_y      = COORD_W'(y);
    req.red        = CHAN_W'(r);
    req.green      = CHAN_W'(g);
    req.blue       = CHAN_W'(b);
    req.water_flag = water;
    req.land_flag  = land;
    send_request(req);
  endtask

  // Random pixel content that makes the bit good or not, by any of the routes.
  task automatic send_pixel(int x, int y, bit want_good);
    tcm_in_t req;
    req       = random_request(OP_WRITE);
    req.pix_x = COORD_W'(x);
    req.pix_y = COORD_W'(y);
    if (want_good) begin
      if ($urandom_range(0, 2) == 0) begin
        req.water_flag = 1'b1;                      // water: good whatever the color
      end else begin
        req.water_flag = 1'b0;
        req.land_flag  = 1'b1;
        if ((req.red | req.green | req.blue) == '0)
          req.green = CHAN_W'($urandom_range(1, 65535));
      end
    end else begin
      req.water_flag = 1'b0;
      if ($urandom_range(0, 1)) begin
        req.land_flag = 1'b0;                       // valid or not, not land
      end else begin
        req.red   = '0;                             // land but no color
        req.green = '0;
        req.blue  = '0;
      end
    end
    send_request(req);
  endtask

  task automatic send_query(int tx, int ty);
    tcm_in_t req;
    req         = random_request(OP_QUERY);
    req.texel_x = TEXEL_W'(tx);
    req.texel_y = TEXEL_W'(ty);
    send_request(req);
  endtask

  // Writes every bit of the window not yet written, then queries it, so no
  // query ever reads an unwritten bit.
  task automatic fill_and_query(int tx, int ty, int good_pct);
    int x0, x1, y0, y1;
    texel_span(tx, clip_size(width_reg), x0, x1);
    texel_span(ty, clip_size(height_reg), y0, y1);
    for (int y = y0; y < y1; y++)
      for (int x = x0; x < x1; x++)
        if (!good_bits.exists(y * SRC_MAX + x))
          send_pixel(x, y, $urandom_range(0, 99) < good_pct);
    send_query(tx, ty);
    last_tx = tx;
    last_ty = ty;
  endtask

  // Size register writes only with the block idle.
  task automatic write_size_reg(cfg_reg_e idx, int value);
    idle_input();
    while (tile_results_due.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= idx;
    cfg_ch.wdata <= SIZE_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_SRC_WIDTH) width_reg = SIZE_W'(value);
    else height_reg = SIZE_W'(value);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Texel choice: anywhere, the atlas edges, or near the previous texel.
  function automatic int pick_texel(int prev);
    int pick;
    int t;
    pick = $urandom_range(0, 9);
    if (pick < 6) return $urandom_range(0, 511);
    if (pick < 8) begin
      case ($urandom_range(0, 3))
        0: return 0;
        1: return 1;
        2: return 510;
        default: return 511;
      endcase
    end
    t = prev + $urandom_range(0, 4) - 2;
    return (t < 0) ? 0 : (t > 511) ? 511 : t;
  endfunction

  function automatic int pick_fill_odds();
    case ($urandom_range(0, 4))
      0, 1: return 100;
      2: return 97;
      3: return 85;
      default: return 40;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Every route to valid/shown/good, channel extremes, far corner of the store.
  task automatic test_pixel_classes();
    send_write_fields(0, 0, 0, 0, 0, 1'b0, 1'b1);                 // land, no color
    send_write_fields(2047, 2047, 65535, 65535, 65535, 1'b0, 1'b1); // shown, off image
    send_write_fields(1, 0, 65535, 0, 0, 1'b1, 1'b0);             // water only
    send_write_fields(2, 0, 0, 1, 0, 1'b1, 1'b1);                 // water and shown
    send_write_fields(3, 0, 0, 0, 32768, 1'b0, 1'b0);             // valid, neither
    send_write_fields(4, 0, 0, 0, 0, 1'b1, 1'b0);                 // water, no color
  endtask

  // Clear, count from zero again, spare opcode leaves everything alone.
  task automatic test_count_clear();
    send_request(random_request(OP_CLEAR));
    send_write_fields(5, 0, 1, 1, 1, 1'b0, 1'b1);
    send_request(random_request(OP_SPARE));
    send_write_fields(6, 0, 0, 0, 0, 1'b1, 1'b1);
    send_request(random_request(OP_CLEAR));
  endtask

  // Zero width: every window is empty and reports covered.
  task automatic test_empty_window();
    write_size_reg(REG_SRC_WIDTH, 0);
    send_query(0, 0);
    send_query(511, 511);
    send_query(255, 0);
  endtask

  // 1x1 image: every texel maps onto pixel (0,0); off-image writes still count
  // but lie outside every window.
  task automatic test_tiny_image();
    write_size_reg(REG_SRC_WIDTH, 1);
    write_size_reg(REG_SRC_HEIGHT, 1);
    send_write_fields(0, 0, 0, 0, 0, 1'b1, 1'b0);
    send_query(0, 0);
    send_query(511, 511);
    send_write_fields(0, 0, 7, 0, 0, 1'b0, 1'b0);
    send_query(0, 0);
    send_write_fields(5, 5, 9, 9, 9, 1'b0, 1'b1);
    send_query(511, 0);
  endtask

  // One size setting: mostly fill-then-query sequences, plus bit flips inside
  // the last window, stray writes, clears and spare opcodes.
  task automatic run_window_phase(int w, int h, int budget);
    int first;
    int pick;
    int pct;
    int x0, x1, y0, y1;
    write_size_reg(REG_SRC_WIDTH, w);
    write_size_reg(REG_SRC_HEIGHT, h);
    first = requests_sent;
    pct   = 100;
    while (requests_sent - first < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        pct = pick_fill_odds();
        fill_and_query(pick_texel(last_tx), pick_texel(last_ty), pct);
      end else if (pick < 65) begin
        texel_span(last_tx, clip_size(width_reg), x0, x1);
        texel_span(last_ty, clip_size(height_reg), y0, y1);
        if (x1 > x0 && y1 > y0)
          send_pixel($urandom_range(x0, x1 - 1), $urandom_range(y0, y1 - 1),
                     1'($urandom_range(0, 1)));
        fill_and_query(last_tx, last_ty, pct);
      end else if (pick < 80) begin
        send_request(random_request(OP_WRITE));
      end else if (pick < 88) begin
        fill_and_query(last_tx, last_ty, pct);
      end else if (pick < 94) begin
        send_request(random_request(OP_CLEAR));
      end else begin
        send_request(random_request(OP_SPARE));
      end
    end
  endtask

  task automatic test_random_windows();
    run_window_phase(8, 8, 150);
    run_window_phase(1, 2048, 150);
    run_window_phase(2048, 3, 150);
    run_window_phase(4095, 13, 120);     // width above the store acts as 2048
    run_window_phase(0, 17, 60);
    run_window_phase(24, 4095, 150);
    run_window_phase(1536, 1536, 100);   // reset sizes: roughly 6x6 windows
    run_window_phase($urandom_range(1, 64), $urandom_range(1, 64), 150);
    run_window_phase(5, 1, 60);
    run_window_phase(4095, 4095, 100);   // largest windows, 7x7
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.data     = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.idx     = REG_SRC_WIDTH;
    cfg_ch.wdata   = '0;
    width_reg      = SIZE_RESET;
    height_reg     = SIZE_RESET;
    shown_total    = '0;
    mismatch_count = 0;
    requests_sent  = 0;
    burst_left     = 0;
    last_tx        = 0;
    last_ty        = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_pixel_classes();
    test_count_clear();
    test_empty_window();
    test_tiny_image();
    test_random_windows();

    // drain: all results in, then a pause to catch stray results
    idle_input();
    while (tile_results_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
